@@ hdl/dpwp_pkg.sv @@
`timescale 1ns / 1ps

package dpwp_pkg;

    localparam int MAX_IMAGE_SIDE = 1024;

    localparam int NUM_W   = 56;
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_DEPTH_PER_COUNT = 3'd0;
    localparam logic [2:0] REG_MIN_DEPTH       = 3'd1;
    localparam logic [2:0] REG_MAX_DIST        = 3'd2;
    localparam logic [2:0] REG_BORDER_MARGIN   = 3'd3;
    localparam logic [2:0] REG_SKIP_STEP       = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd6;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    // ceil(65536 / d), entry zero unused
    localparam logic [16:0] RECIP_TAB [0:31] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923,
        17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,
        17'd4682,  17'd4370,  17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,
        17'd3121,  17'd2979,  17'd2850,  17'd2731,  17'd2622,  17'd2521,  17'd2428,
        17'd2341,  17'd2260,  17'd2185,  17'd2115
    };

    typedef struct packed {
        logic        vld;
        logic        ld;
        logic [3:0]  idx;
        logic [31:0] val;
        logic        clamped;
        logic [22:0] depth;
        logic        negx;
        logic        negy;
        logic        zx;
        logic        zy;
    } dpwp_ctl_t;

    function automatic logic signed [31:0] sat_quo(input logic [QUO_W-1:0] q, input logic ovf,
                                                   input logic neg, input logic z);
        logic signed [31:0] r;
        if (z) begin
            r = '0;
        end else if (neg) begin
            if (ovf || q > 32'h8000_0000) begin
                r = 32'sh8000_0000;
            end else begin
                r = $signed(-q);
            end
        end else begin
            if (ovf || q[31]) begin
                r = 32'sh7fff_ffff;
            end else begin
                r = $signed(q);
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_world(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -51'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/dpwp_div.sv @@
`timescale 1ns / 1ps

module dpwp_div (
    input  logic                         aclk,
    input  logic                         ce,
    input  logic [dpwp_pkg::NUM_W-1:0]   num_i,
    input  logic [dpwp_pkg::DEN_W-1:0]   den_i,
    output logic [dpwp_pkg::QUO_W-1:0]   quo_o,
    output logic                         ovf_o
);

    localparam int NW = dpwp_pkg::NUM_W;
    localparam int DW = dpwp_pkg::DEN_W;
    localparam int QW = dpwp_pkg::QUO_W;
    localparam int CW = DW + QW;

    logic [NW-1:0] rem_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          ovf_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= num_i;
            den_reg[0] <= den_i;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CW'(num_i) >= {den_i, {QW{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int J = QW - k;
        logic [CW-1:0] trial;
        logic          ge;
        assign trial = CW'(den_reg[k-1]) << J;
        assign ge    = CW'(rem_reg[k-1]) >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= ge ? rem_reg[k-1] - trial[NW-1:0] : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (QW'(ge) << J);
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo_o = quo_reg[QW];
    assign ovf_o = ovf_reg[QW];

endmodule

@@ hdl/depth_pixel_to_world_point_core.sv @@
`timescale 1ns / 1ps
// Depth pixel to world point back-projection.
// Input channel s_*: one beat per pixel (s_req_type low) or per coefficient
// table load (s_req_type high, s_coef_index / s_coef_value). Load the whole
// table before the first pixel; loads and pixels stay in order, so a load
// only affects pixels sent after it.
// Result channel m_*: one beat per surviving pixel, world x/y/z in Q16.16 and
// the range clamp flag. Pixels off the window or grid, or nearer than the
// minimum depth, give no beat; loads never give one.
// Configuration: APB port, register i at byte address 4*i, pready tied high.
// The x and y projections run through 33-stage radix-2 divider pipelines.
// Throughput: one beat per cycle while the result channel is not stalled.
// Reset clears all valid bits and loads the configuration defaults; the
// coefficient table holds garbage until written.
// When m_ready is low while a result waits, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
module depth_pixel_to_world_point_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [9:0]                       s_col,
    input  logic [9:0]                       s_row,
    input  logic [15:0]                      s_raw_depth,
    input  logic [3:0]                       s_coef_index,
    input  logic signed [31:0]               s_coef_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_world_x,
    output logic signed [31:0]               m_world_y,
    output logic signed [31:0]               m_world_z,
    output logic                             m_range_clamped,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dpwp_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int DL = dpwp_pkg::DIV_LAT;

    // configuration
    logic [31:0] dpc_reg;
    logic [22:0] min_reg;
    logic [22:0] max_reg;
    logic [7:0]  margin_reg;
    logic [4:0]  step_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpc_reg    <= 32'd16777;
            min_reg    <= 23'd13107;
            max_reg    <= 23'd327680;
            margin_reg <= 8'd0;
            step_reg   <= 5'd1;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                dpwp_pkg::REG_DEPTH_PER_COUNT: dpc_reg    <= pwdata;
                dpwp_pkg::REG_MIN_DEPTH:       min_reg    <= pwdata[22:0];
                dpwp_pkg::REG_MAX_DIST:        max_reg    <= pwdata[22:0];
                dpwp_pkg::REG_BORDER_MARGIN:   margin_reg <= pwdata[7:0];
                dpwp_pkg::REG_SKIP_STEP:       step_reg   <= pwdata[4:0];
                dpwp_pkg::REG_IMAGE_WIDTH:     width_reg  <= pwdata[10:0];
                dpwp_pkg::REG_IMAGE_HEIGHT:    height_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            dpwp_pkg::REG_DEPTH_PER_COUNT: prdata = dpc_reg;
            dpwp_pkg::REG_MIN_DEPTH:       prdata = 32'(min_reg);
            dpwp_pkg::REG_MAX_DIST:        prdata = 32'(max_reg);
            dpwp_pkg::REG_BORDER_MARGIN:   prdata = 32'(margin_reg);
            dpwp_pkg::REG_SKIP_STEP:       prdata = 32'(step_reg);
            dpwp_pkg::REG_IMAGE_WIDTH:     prdata = 32'(width_reg);
            dpwp_pkg::REG_IMAGE_HEIGHT:    prdata = 32'(height_reg);
            default:                       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // stage 1: input capture
    logic        s1_vld_reg;
    logic        s1_ld_reg;
    logic [9:0]  s1_col_reg;
    logic [9:0]  s1_row_reg;
    logic [15:0] s1_raw_reg;
    logic [3:0]  s1_idx_reg;
    logic [31:0] s1_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (ce) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_ld_reg  <= s_req_type == dpwp_pkg::REQ_LOAD;
            s1_col_reg <= s_col;
            s1_row_reg <= s_row;
            s1_raw_reg <= s_raw_depth;
            s1_idx_reg <= s_coef_index;
            s1_val_reg <= s_coef_value;
        end
    end

    // stage 2: window, grid offset, raw scale
    logic [10:0] width_lim;
    logic [10:0] height_lim;
    logic [10:0] cm_sum;
    logic [10:0] rm_sum;
    logic        win_ok;
    logic [4:0]  step_eff;

    assign width_lim  = ({2'b0, width_reg} > 13'(dpwp_pkg::MAX_IMAGE_SIDE)) ?
                        11'(dpwp_pkg::MAX_IMAGE_SIDE) : width_reg;
    assign height_lim = ({2'b0, height_reg} > 13'(dpwp_pkg::MAX_IMAGE_SIDE)) ?
                        11'(dpwp_pkg::MAX_IMAGE_SIDE) : height_reg;
    assign cm_sum     = {1'b0, s1_col_reg} + {3'b0, margin_reg};
    assign rm_sum     = {1'b0, s1_row_reg} + {3'b0, margin_reg};
    assign win_ok     = (s1_col_reg >= {2'b0, margin_reg}) && (cm_sum < width_lim) &&
                        (s1_row_reg >= {2'b0, margin_reg}) && (rm_sum < height_lim);
    assign step_eff   = (step_reg == 5'd0) ? 5'd1 : step_reg;

    logic        s2_vld_reg;
    logic        s2_ld_reg;
    logic [9:0]  s2_col_reg;
    logic [9:0]  s2_row_reg;
    logic [9:0]  s2_cpix_reg;
    logic [9:0]  s2_rpix_reg;
    logic [4:0]  s2_step_reg;
    logic        s2_rawz_reg;
    logic [47:0] s2_dprod_reg;
    logic [3:0]  s2_idx_reg;
    logic [31:0] s2_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (ce) begin
            s2_vld_reg <= s1_vld_reg && (s1_ld_reg || win_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_ld_reg    <= s1_ld_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_cpix_reg  <= s1_col_reg - {2'b0, margin_reg};
            s2_rpix_reg  <= s1_row_reg - {2'b0, margin_reg};
            s2_step_reg  <= step_eff;
            s2_rawz_reg  <= s1_raw_reg == 16'd0;
            s2_dprod_reg <= 48'(s1_raw_reg) * 48'(dpc_reg);
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
        end
    end

    // stage 3: grid quotient, depth clamp
    logic [26:0] qc_full;
    logic [26:0] qr_full;
    logic [48:0] dep_round;
    logic [40:0] dep_full;
    logic        dep_big;
    logic        dep_small;

    assign qc_full   = 27'(s2_cpix_reg) * 27'(dpwp_pkg::RECIP_TAB[s2_step_reg]);
    assign qr_full   = 27'(s2_rpix_reg) * 27'(dpwp_pkg::RECIP_TAB[s2_step_reg]);
    assign dep_round = 49'(s2_dprod_reg) + 49'd128;
    assign dep_full  = dep_round[48:8];
    assign dep_big   = s2_rawz_reg || (dep_full > 41'(max_reg));
    assign dep_small = dep_full < 41'(min_reg);

    logic        s3_vld_reg;
    logic        s3_ld_reg;
    logic [9:0]  s3_col_reg;
    logic [9:0]  s3_row_reg;
    logic [9:0]  s3_cpix_reg;
    logic [9:0]  s3_rpix_reg;
    logic [9:0]  s3_qc_reg;
    logic [9:0]  s3_qr_reg;
    logic [4:0]  s3_step_reg;
    logic [22:0] s3_depth_reg;
    logic        s3_clamped_reg;
    logic [3:0]  s3_idx_reg;
    logic [31:0] s3_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (ce) begin
            s3_vld_reg <= s2_vld_reg && (s2_ld_reg || dep_big || !dep_small);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_ld_reg      <= s2_ld_reg;
            s3_col_reg     <= s2_col_reg;
            s3_row_reg     <= s2_row_reg;
            s3_cpix_reg    <= s2_cpix_reg;
            s3_rpix_reg    <= s2_rpix_reg;
            s3_qc_reg      <= qc_full[25:16];
            s3_qr_reg      <= qr_full[25:16];
            s3_step_reg    <= s2_step_reg;
            s3_depth_reg   <= dep_big ? max_reg : dep_full[22:0];
            s3_clamped_reg <= dep_big;
            s3_idx_reg     <= s2_idx_reg;
            s3_val_reg     <= s2_val_reg;
        end
    end

    // intrinsics, updated in order with the pixel stream
    logic signed [31:0] ft_reg [0:3];

    always_ff @(posedge aclk) begin
        if (ce && s3_vld_reg && s3_ld_reg && s3_idx_reg[3:2] == 2'b11) begin
            ft_reg[s3_idx_reg[1:0]] <= s3_val_reg;
        end
    end

    // stage 4: grid check, centered pixel
    logic grid_ok;
    assign grid_ok = (15'(s3_cpix_reg) == 15'(s3_qc_reg) * 15'(s3_step_reg)) &&
                     (15'(s3_rpix_reg) == 15'(s3_qr_reg) * 15'(s3_step_reg));

    logic               s4_vld_reg;
    logic               s4_ld_reg;
    logic signed [32:0] s4_dx_reg;
    logic signed [32:0] s4_dy_reg;
    logic signed [31:0] s4_fx_reg;
    logic signed [31:0] s4_fy_reg;
    logic [22:0]        s4_depth_reg;
    logic               s4_clamped_reg;
    logic [3:0]         s4_idx_reg;
    logic [31:0]        s4_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (ce) begin
            s4_vld_reg <= s3_vld_reg && (s3_ld_reg || grid_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_ld_reg      <= s3_ld_reg;
            s4_dx_reg      <= $signed({7'b0, s3_col_reg, 16'b0}) -
                              $signed({ft_reg[2][31], ft_reg[2]});
            s4_dy_reg      <= $signed({7'b0, s3_row_reg, 16'b0}) -
                              $signed({ft_reg[3][31], ft_reg[3]});
            s4_fx_reg      <= ft_reg[0];
            s4_fy_reg      <= ft_reg[1];
            s4_depth_reg   <= s3_depth_reg;
            s4_clamped_reg <= s3_clamped_reg;
            s4_idx_reg     <= s3_idx_reg;
            s4_val_reg     <= s3_val_reg;
        end
    end

    // stage 5: scale by depth
    logic               s5_vld_reg;
    logic               s5_ld_reg;
    logic signed [56:0] s5_px_reg;
    logic signed [56:0] s5_py_reg;
    logic signed [31:0] s5_fx_reg;
    logic signed [31:0] s5_fy_reg;
    logic [22:0]        s5_depth_reg;
    logic               s5_clamped_reg;
    logic [3:0]         s5_idx_reg;
    logic [31:0]        s5_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (ce) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s5_ld_reg      <= s4_ld_reg;
            s5_px_reg      <= 57'(s4_dx_reg) * 57'($signed({1'b0, s4_depth_reg}));
            s5_py_reg      <= 57'(s4_dy_reg) * 57'($signed({1'b0, s4_depth_reg}));
            s5_fx_reg      <= s4_fx_reg;
            s5_fy_reg      <= s4_fy_reg;
            s5_depth_reg   <= s4_depth_reg;
            s5_clamped_reg <= s4_clamped_reg;
            s5_idx_reg     <= s4_idx_reg;
            s5_val_reg     <= s4_val_reg;
        end
    end

    // stage 6: magnitudes and signs for the dividers
    logic [56:0] px_abs;
    logic [56:0] py_abs;
    assign px_abs = s5_px_reg[56] ? 57'(-s5_px_reg) : 57'(s5_px_reg);
    assign py_abs = s5_py_reg[56] ? 57'(-s5_py_reg) : 57'(s5_py_reg);

    logic [dpwp_pkg::NUM_W-1:0] s6_nx_reg;
    logic [dpwp_pkg::NUM_W-1:0] s6_ny_reg;
    logic [dpwp_pkg::DEN_W-1:0] s6_dx_reg;
    logic [dpwp_pkg::DEN_W-1:0] s6_dy_reg;
    dpwp_pkg::dpwp_ctl_t        s6_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_ctl_reg.vld <= 1'b0;
        end else if (ce) begin
            s6_ctl_reg.vld <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s6_nx_reg          <= px_abs[dpwp_pkg::NUM_W-1:0];
            s6_ny_reg          <= py_abs[dpwp_pkg::NUM_W-1:0];
            s6_dx_reg          <= s5_fx_reg[31] ? 32'(-s5_fx_reg) : 32'(s5_fx_reg);
            s6_dy_reg          <= s5_fy_reg[31] ? 32'(-s5_fy_reg) : 32'(s5_fy_reg);
            s6_ctl_reg.ld      <= s5_ld_reg;
            s6_ctl_reg.idx     <= s5_idx_reg;
            s6_ctl_reg.val     <= s5_val_reg;
            s6_ctl_reg.clamped <= s5_clamped_reg;
            s6_ctl_reg.depth   <= s5_depth_reg;
            s6_ctl_reg.negx    <= s5_px_reg[56] ^ s5_fx_reg[31];
            s6_ctl_reg.negy    <= s5_py_reg[56] ^ s5_fy_reg[31];
            s6_ctl_reg.zx      <= s5_fx_reg == 32'sd0;
            s6_ctl_reg.zy      <= s5_fy_reg == 32'sd0;
        end
    end

    // divider pipelines
    logic [dpwp_pkg::QUO_W-1:0] qx;
    logic [dpwp_pkg::QUO_W-1:0] qy;
    logic                       ovx;
    logic                       ovy;

    dpwp_div u_div_x (
        .aclk  (aclk),
        .ce    (ce),
        .num_i (s6_nx_reg),
        .den_i (s6_dx_reg),
        .quo_o (qx),
        .ovf_o (ovx)
    );

    dpwp_div u_div_y (
        .aclk  (aclk),
        .ce    (ce),
        .num_i (s6_ny_reg),
        .den_i (s6_dy_reg),
        .quo_o (qy),
        .ovf_o (ovy)
    );

    dpwp_pkg::dpwp_ctl_t dctl_reg [0:DL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) begin
                dctl_reg[i].vld <= 1'b0;
            end
        end else if (ce) begin
            dctl_reg[0].vld <= s6_ctl_reg.vld;
            for (int i = 1; i < DL; i++) begin
                dctl_reg[i].vld <= dctl_reg[i-1].vld;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dctl_reg[0].ld      <= s6_ctl_reg.ld;
            dctl_reg[0].idx     <= s6_ctl_reg.idx;
            dctl_reg[0].val     <= s6_ctl_reg.val;
            dctl_reg[0].clamped <= s6_ctl_reg.clamped;
            dctl_reg[0].depth   <= s6_ctl_reg.depth;
            dctl_reg[0].negx    <= s6_ctl_reg.negx;
            dctl_reg[0].negy    <= s6_ctl_reg.negy;
            dctl_reg[0].zx      <= s6_ctl_reg.zx;
            dctl_reg[0].zy      <= s6_ctl_reg.zy;
            for (int i = 1; i < DL; i++) begin
                dctl_reg[i].ld      <= dctl_reg[i-1].ld;
                dctl_reg[i].idx     <= dctl_reg[i-1].idx;
                dctl_reg[i].val     <= dctl_reg[i-1].val;
                dctl_reg[i].clamped <= dctl_reg[i-1].clamped;
                dctl_reg[i].depth   <= dctl_reg[i-1].depth;
                dctl_reg[i].negx    <= dctl_reg[i-1].negx;
                dctl_reg[i].negy    <= dctl_reg[i-1].negy;
                dctl_reg[i].zx      <= dctl_reg[i-1].zx;
                dctl_reg[i].zy      <= dctl_reg[i-1].zy;
            end
        end
    end

    // stage 7: camera point
    logic               s7_vld_reg;
    logic               s7_ld_reg;
    logic signed [31:0] s7_cx_reg;
    logic signed [31:0] s7_cy_reg;
    logic [22:0]        s7_depth_reg;
    logic               s7_clamped_reg;
    logic [3:0]         s7_idx_reg;
    logic [31:0]        s7_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (ce) begin
            s7_vld_reg <= dctl_reg[DL-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s7_ld_reg      <= dctl_reg[DL-1].ld;
            s7_cx_reg      <= dpwp_pkg::sat_quo(qx, ovx, dctl_reg[DL-1].negx,
                                                dctl_reg[DL-1].zx);
            s7_cy_reg      <= dpwp_pkg::sat_quo(qy, ovy, dctl_reg[DL-1].negy,
                                                dctl_reg[DL-1].zy);
            s7_depth_reg   <= dctl_reg[DL-1].depth;
            s7_clamped_reg <= dctl_reg[DL-1].clamped;
            s7_idx_reg     <= dctl_reg[DL-1].idx;
            s7_val_reg     <= dctl_reg[DL-1].val;
        end
    end

    // rotation and position, updated in order with the pixel stream
    logic signed [31:0] bt_reg [0:11];

    always_ff @(posedge aclk) begin
        if (ce && s7_vld_reg && s7_ld_reg && s7_idx_reg < 4'd12) begin
            bt_reg[s7_idx_reg] <= s7_val_reg;
        end
    end

    // stage 8: rotation products
    logic signed [31:0] cam [0:2];
    assign cam[0] = s7_cx_reg;
    assign cam[1] = s7_cy_reg;
    assign cam[2] = $signed({9'b0, s7_depth_reg});

    logic               s8_vld_reg;
    logic signed [63:0] s8_p_reg [0:8];
    logic signed [31:0] s8_pos_reg [0:2];
    logic               s8_clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_vld_reg <= 1'b0;
        end else if (ce) begin
            s8_vld_reg <= s7_vld_reg && !s7_ld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    s8_p_reg[i*3+k] <= 64'(bt_reg[i*3+k]) * 64'(cam[k]);
                end
                s8_pos_reg[i] <= bt_reg[9+i];
            end
            s8_clamped_reg <= s7_clamped_reg;
        end
    end

    // stage 9: row sums
    logic               s9_vld_reg;
    logic signed [65:0] s9_sum_reg [0:2];
    logic signed [31:0] s9_pos_reg [0:2];
    logic               s9_clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s9_vld_reg <= 1'b0;
        end else if (ce) begin
            s9_vld_reg <= s8_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s9_sum_reg[i] <= 66'(s8_p_reg[i*3]) + 66'(s8_p_reg[i*3+1]) +
                                 66'(s8_p_reg[i*3+2]);
                s9_pos_reg[i] <= s8_pos_reg[i];
            end
            s9_clamped_reg <= s8_clamped_reg;
        end
    end

    // stage 10: shift, translate, saturate
    logic signed [50:0] wsum [0:2];
    for (genvar i = 0; i < 3; i++) begin : g_world
        assign wsum[i] = 51'($signed(s9_sum_reg[i][65:16])) + 51'(s9_pos_reg[i]);
    end

    logic               out_vld_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic               out_clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= s9_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_x_reg       <= dpwp_pkg::sat_world(wsum[0]);
            out_y_reg       <= dpwp_pkg::sat_world(wsum[1]);
            out_z_reg       <= dpwp_pkg::sat_world(wsum[2]);
            out_clamped_reg <= s9_clamped_reg;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_world_x       = out_x_reg;
    assign m_world_y       = out_y_reg;
    assign m_world_z       = out_z_reg;
    assign m_range_clamped = out_clamped_reg;

endmodule

@@ hdl/dpwp_chk.sv @@
`timescale 1ns / 1ps

module dpwp_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_world_x,
    input logic signed [31:0] m_world_y,
    input logic signed [31:0] m_world_z,
    input logic               m_range_clamped,
    input logic               pready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_world_x) && $stable(m_world_y) &&
        $stable(m_world_z) && $stable(m_range_clamped))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && pready)
        else $error("input held off with empty output");

endmodule

bind depth_pixel_to_world_point_core dpwp_chk u_dpwp_chk (.*);
